// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, quiet while reset is held
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, quiet while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/gdn_pkg.sv =====
// types and fixed constants of the globe day/night pixel shader
// no dependencies; used by gdn_scale565 and the top level
package gdn_pkg;

    typedef logic [23:0] t_rgb888;
    typedef logic [15:0] t_rgb565;

    // item opcodes carried on tuser
    localparam logic [1:0] OP_SHADE = 2'd0;
    localparam logic [1:0] OP_MASK  = 2'd1;
    localparam logic [1:0] OP_COS   = 2'd2;

    // what an item does once inside the pipeline
    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_MASK,
        KIND_COS
    } t_kind;

    // configuration register indexes
    localparam logic [2:0] CFG_BASE_COLUMN = 3'd0;
    localparam logic [2:0] CFG_SIN_DECL    = 3'd1;
    localparam logic [2:0] CFG_COS_DECL    = 3'd2;
    localparam logic [2:0] CFG_LAND_COLOR  = 3'd3;
    localparam logic [2:0] CFG_OCEAN_COLOR = 3'd4;
    localparam logic [2:0] CFG_SPACE_COLOR = 3'd5;

    // register reset values
    localparam logic [8:0]         RST_BASE_COLUMN = 9'd296;
    localparam logic signed [15:0] RST_SIN_DECL    = 16'sd0;
    localparam logic signed [15:0] RST_COS_DECL    = 16'sd32767;
    localparam t_rgb888            RST_LAND_COLOR  = 24'h3E6B34;
    localparam t_rgb888            RST_OCEAN_COLOR = 24'h103248;
    localparam t_rgb888            RST_SPACE_COLOR = 24'h100A05;

    // lighting: zenith cosine in Q2.30, light factor in Q1.16
    localparam longint DAY_TH     = 107374182;  // 0.10
    localparam int     NIGHT_Q16  = 18350;      // 0.28
    localparam int     FULL_Q16   = 65536;      // 1.0
    // ramp = floor(x * 9 / 40960), x = cz + 0.10
    localparam int     RAMP_MUL   = 9;
    localparam int     RAMP_DIV   = 40960;
    localparam longint RAMP_RECIP = 943718;     // floor(9 * 2^32 / 40960)
    localparam int     RAMP_XW    = 28;         // width of cz + 0.10 inside the ramp

endpackage

// ===== rtl/gdn_scale565.sv =====
// scales an RGB888 color by an 8-bit shade and packs it as RGB565
// depends on gdn_pkg for the color types
module gdn_scale565 import gdn_pkg::*; (
    input  t_rgb888    i_color,
    input  logic [7:0] i_shade,
    output t_rgb565    o_rgb565
);

    logic [15:0] w_red;
    logic [15:0] w_green;
    logic [15:0] w_blue;

    // channel times shade, the top byte is the scaled channel
    assign w_red   = 16'(i_color[23:16]) * 16'(i_shade);
    assign w_green = 16'(i_color[15:8])  * 16'(i_shade);
    assign w_blue  = 16'(i_color[7:0])   * 16'(i_shade);

    // keep the top 5/6/5 bits of each scaled channel
    assign o_rgb565 = {w_red[15:11], w_green[15:10], w_blue[15:11]};

endmodule

// ===== rtl/globe_day_night_pixel_shader_core.sv =====
// Globe day/night pixel shader: one item per clock at full rate, registered through stages 1 to 9
// into the result register. Shade items (tuser 0) give one RGB565 result each, in
// order; load items (tuser 1 mask byte, tuser 2 sun cosine entry) and tuser 3 give none.
// Loads travel down the same pipeline and write the table at the stage where pixels read
// it, so a pixel always sees every load sent before it and none sent after. Both tables
// come up undefined after reset and must be loaded before pixels read them; there is no
// clearing pass. Throughput is one item per clock and drops only while the output is held;
// each of the ten register stages has its own enable, so bubbles close up during a stall.
// depends on gdn_pkg, gdn_scale565 and assert_macros.svh
`include "assert_macros.svh"

module globe_day_night_pixel_shader_core import gdn_pkg::*; #(
    parameter int MASK_W = 360,
    parameter int MASK_H = 180
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tuser: op[1:0]
    input  logic [1:0]  i_s_tuser,
    // tdata: off_disc[0], mask_row[8:1], col_offset[17:9], limb_shade[25:18],
    //        sin_lat[41:26], cos_lat[56:42], table_index[69:57], mask_byte[77:70],
    //        cos_value[93:78], zero[95:94]
    input  logic [95:0] i_s_tdata,
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: pixel_rgb565[15:0]
    output logic [15:0] o_m_tdata,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int CW        = $clog2(MASK_W);
    localparam int RW        = $clog2(MASK_H);
    localparam int IW        = $clog2(MASK_W * MASK_H);
    localparam int MAP_BYTES = (MASK_W * MASK_H + 7) / 8;
    localparam int AW        = $clog2(MAP_BYTES);
    // smallest multiple of the width that lifts base+offset above zero
    localparam int KW        = ((256 + MASK_W - 1) / MASK_W) * MASK_W;
    localparam int UMAX      = 766 + KW;
    localparam int UW        = $clog2(UMAX + 1);
    localparam int COL_RECIP = (1 << UW) / MASK_W;

    localparam logic signed [32:0] CZ_DAY   = 33'(DAY_TH);
    localparam logic signed [32:0] CZ_NIGHT = -CZ_DAY;

    // configuration registers
    logic [8:0]         r_base_column;
    logic signed [15:0] r_sin_decl;
    logic signed [15:0] r_cos_decl;
    t_rgb888            r_land_color;
    t_rgb888            r_ocean_color;
    t_rgb888            r_space_color;

    // tables
    logic [7:0]         r_land_map [MAP_BYTES];
    logic [15:0]        r_sun_cos  [MASK_W];

    // stage valids and advance enables
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic r_s6_valid, r_s7_valid, r_s8_valid, r_s9_valid, r_out_valid;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6, w_en7, w_en8, w_en9, w_en_out;

    // input field split
    logic               w_off_disc;
    logic [7:0]         w_mask_row;
    logic signed [8:0]  w_col_offset;
    logic [7:0]         w_limb_shade;
    logic signed [15:0] w_sin_lat;
    logic [14:0]        w_cos_lat;
    logic [12:0]        w_table_index;
    logic [7:0]         w_mask_byte;
    logic [15:0]        w_cos_value;

    // stage 1 decode and products
    t_kind              w_kind;
    logic               w_keep;
    logic [RW-1:0]      w_row;
    logic signed [UW:0] w_u_s;
    logic [15:0]        w_ldata;

    t_kind              r_s1_kind, r_s2_kind, r_s3_kind, r_s4_kind;
    logic [12:0]        r_s1_tidx, r_s2_tidx, r_s3_tidx, r_s4_tidx;
    logic [15:0]        r_s1_ldata, r_s2_ldata, r_s3_ldata, r_s4_ldata;
    logic               r_s1_off, r_s2_off, r_s3_off, r_s4_off, r_s5_off;
    logic               r_s6_off, r_s7_off, r_s8_off, r_s9_off;
    logic [7:0]         r_s1_limb, r_s2_limb, r_s3_limb, r_s4_limb, r_s5_limb;
    logic [7:0]         r_s6_limb, r_s7_limb, r_s8_limb;
    logic [RW-1:0]      r_s1_row, r_s2_row;
    logic [UW-1:0]      r_s1_u;
    logic [2*UW-1:0]    r_s1_uq;
    logic signed [31:0] r_s1_p1, r_s2_p1, r_s3_p1, r_s4_p1, r_s5_p1;
    logic signed [31:0] r_s1_p2;

    // stage 2
    logic [UW-1:0]      w_colq;
    logic [CW:0]        r_s2_rraw;
    logic signed [15:0] r_s2_q2, r_s3_q2, r_s4_q2;

    // stage 3
    logic [CW-1:0]      r_s3_col;
    logic [IW-1:0]      r_s3_rowbase;

    // stage 4
    logic [IW-1:0]      r_s4_idx;
    logic [15:0]        r_s4_cos;

    // stage 5
    logic [7:0]         r_s5_byte;
    logic [2:0]         r_s5_bsel;
    logic signed [31:0] r_s5_prod;

    // stage 6
    logic signed [32:0] w_cz;
    logic [32:0]        w_cz_lift;
    logic               r_s6_day, r_s7_day;
    logic               r_s6_night, r_s7_night;
    logic [RAMP_XW-1:0] r_s6_x;
    logic               r_s6_land, r_s7_land, r_s8_land;

    // stage 7
    logic [47:0]        r_s7_prod;
    logic [31:0]        r_s7_x9;

    // stage 8
    logic [15:0]        w_rq;
    logic [31:0]        w_rem;
    logic [15:0]        w_ramp;
    logic [16:0]        r_s8_d;

    // stage 9
    logic [24:0]        w_lit;
    logic [7:0]         r_s9_shade;
    t_rgb888            r_s9_color;

    // output
    t_rgb565            w_scaled;
    t_rgb565            w_space565;
    logic [15:0]        r_out_data;

    // stall chain: a stage loads when empty or when its successor moves
    assign w_en_out = !r_out_valid || i_m_tready;
    assign w_en9    = !r_s9_valid || w_en_out;
    assign w_en8    = !r_s8_valid || w_en9;
    assign w_en7    = !r_s7_valid || w_en8;
    assign w_en6    = !r_s6_valid || w_en7;
    assign w_en5    = !r_s5_valid || w_en6;
    assign w_en4    = !r_s4_valid || w_en5;
    assign w_en3    = !r_s3_valid || w_en4;
    assign w_en2    = !r_s2_valid || w_en3;
    assign w_en1    = !r_s1_valid || w_en2;

    assign o_s_tready  = w_en1;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_column <= RST_BASE_COLUMN;
            r_sin_decl    <= RST_SIN_DECL;
            r_cos_decl    <= RST_COS_DECL;
            r_land_color  <= RST_LAND_COLOR;
            r_ocean_color <= RST_OCEAN_COLOR;
            r_space_color <= RST_SPACE_COLOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_COLUMN: r_base_column <= i_cfg_data[8:0];
                CFG_SIN_DECL:    r_sin_decl    <= i_cfg_data[15:0];
                CFG_COS_DECL:    r_cos_decl    <= i_cfg_data[15:0];
                CFG_LAND_COLOR:  r_land_color  <= i_cfg_data;
                CFG_OCEAN_COLOR: r_ocean_color <= i_cfg_data;
                CFG_SPACE_COLOR: r_space_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input field split
    assign w_off_disc    = i_s_tdata[0];
    assign w_mask_row    = i_s_tdata[8:1];
    assign w_col_offset  = i_s_tdata[17:9];
    assign w_limb_shade  = i_s_tdata[25:18];
    assign w_sin_lat     = i_s_tdata[41:26];
    assign w_cos_lat     = i_s_tdata[56:42];
    assign w_table_index = i_s_tdata[69:57];
    assign w_mask_byte   = i_s_tdata[77:70];
    assign w_cos_value   = i_s_tdata[93:78];

    // op decode; out-of-range loads and unknown ops are dropped here
    always_comb begin
        w_kind  = KIND_PIXEL;
        w_keep  = 1'b0;
        w_ldata = w_cos_value;
        case (i_s_tuser)
            OP_SHADE: begin
                w_kind = KIND_PIXEL;
                w_keep = 1'b1;
            end
            OP_MASK: begin
                w_kind  = KIND_MASK;
                w_keep  = (32'(w_table_index) < MAP_BYTES);
                w_ldata = {8'd0, w_mask_byte};
            end
            OP_COS: begin
                w_kind = KIND_COS;
                w_keep = (32'(w_table_index) < MASK_W);
            end
            default: w_keep = 1'b0;
        endcase
    end

    // row clamp and lifted column sum
    assign w_row = (32'(w_mask_row) >= MASK_H) ? RW'(MASK_H - 1) : RW'(w_mask_row);
    assign w_u_s = (UW+1)'($signed({1'b0, r_base_column})) + (UW+1)'(w_col_offset)
                 + (UW+1)'(KW);

    // stage 1: decode, latitude products, column reciprocal product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= i_s_tvalid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_kind  <= w_kind;
            r_s1_tidx  <= w_table_index;
            r_s1_ldata <= w_ldata;
            r_s1_off   <= w_off_disc;
            r_s1_limb  <= w_limb_shade;
            r_s1_row   <= w_row;
            r_s1_u     <= w_u_s[UW-1:0];
            r_s1_uq    <= (2*UW)'(w_u_s[UW-1:0]) * (2*UW)'(COL_RECIP);
            r_s1_p1    <= w_sin_lat * r_sin_decl;
            r_s1_p2    <= $signed({1'b0, w_cos_lat}) * r_cos_decl;
        end
    end

    // stage 2: column remainder before correction, floor of cos product
    assign w_colq = r_s1_uq[2*UW-1:UW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_tidx  <= r_s1_tidx;
            r_s2_ldata <= r_s1_ldata;
            r_s2_off   <= r_s1_off;
            r_s2_limb  <= r_s1_limb;
            r_s2_row   <= r_s1_row;
            r_s2_p1    <= r_s1_p1;
            r_s2_rraw  <= (CW+1)'(r_s1_u - UW'(w_colq * MASK_W));
            r_s2_q2    <= r_s1_p2[30:15];
        end
    end

    // stage 3: final column, row base address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_kind    <= r_s2_kind;
            r_s3_tidx    <= r_s2_tidx;
            r_s3_ldata   <= r_s2_ldata;
            r_s3_off     <= r_s2_off;
            r_s3_limb    <= r_s2_limb;
            r_s3_p1      <= r_s2_p1;
            r_s3_q2      <= r_s2_q2;
            r_s3_col     <= (r_s2_rraw >= (CW+1)'(MASK_W)) ?
                            CW'(r_s2_rraw - (CW+1)'(MASK_W)) : CW'(r_s2_rraw);
            r_s3_rowbase <= IW'(r_s2_row * MASK_W);
        end
    end

    // stage 4: sun cosine table port, mask bit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            if (r_s3_valid && r_s3_kind == KIND_COS) begin
                r_sun_cos[r_s3_tidx[CW-1:0]] <= r_s3_ldata;
            end
            r_s4_cos   <= r_sun_cos[r_s3_col];
            r_s4_kind  <= r_s3_kind;
            r_s4_tidx  <= r_s3_tidx;
            r_s4_ldata <= r_s3_ldata;
            r_s4_off   <= r_s3_off;
            r_s4_limb  <= r_s3_limb;
            r_s4_p1    <= r_s3_p1;
            r_s4_q2    <= r_s3_q2;
            r_s4_idx   <= r_s3_rowbase + IW'(r_s3_col);
        end
    end

    // stage 5: land bitmap port, longitude product; loads leave the pipe here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_en5) begin
            r_s5_valid <= r_s4_valid && (r_s4_kind == KIND_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            if (r_s4_valid && r_s4_kind == KIND_MASK) begin
                r_land_map[AW'(r_s4_tidx)] <= r_s4_ldata[7:0];
            end
            r_s5_byte <= r_land_map[AW'(r_s4_idx >> 3)];
            r_s5_bsel <= r_s4_idx[2:0];
            r_s5_off  <= r_s4_off;
            r_s5_limb <= r_s4_limb;
            r_s5_p1   <= r_s4_p1;
            r_s5_prod <= r_s4_q2 * $signed(r_s4_cos);
        end
    end

    // stage 6: zenith cosine, day/night thresholds, ramp operand
    assign w_cz      = 33'(r_s5_p1) + 33'(r_s5_prod);
    assign w_cz_lift = w_cz + CZ_DAY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (w_en6) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r_s6_off   <= r_s5_off;
            r_s6_limb  <= r_s5_limb;
            r_s6_day   <= (w_cz >= CZ_DAY);
            r_s6_night <= (w_cz <= CZ_NIGHT);
            r_s6_x     <= w_cz_lift[RAMP_XW-1:0];
            r_s6_land  <= r_s5_byte[3'd7 - r_s5_bsel];
        end
    end

    // stage 7: ramp quotient estimate by reciprocal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (w_en7) begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en7) begin
            r_s7_off   <= r_s6_off;
            r_s7_limb  <= r_s6_limb;
            r_s7_day   <= r_s6_day;
            r_s7_night <= r_s6_night;
            r_s7_land  <= r_s6_land;
            r_s7_prod  <= 48'(r_s6_x) * 48'(RAMP_RECIP);
            r_s7_x9    <= 32'(r_s6_x) * 32'(RAMP_MUL);
        end
    end

    // stage 8: quotient correction and light factor select
    assign w_rq   = r_s7_prod[47:32];
    assign w_rem  = r_s7_x9 - 32'(w_rq) * 32'(RAMP_DIV);
    assign w_ramp = w_rq + 16'(w_rem >= 32'(RAMP_DIV));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (w_en8) begin
            r_s8_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en8) begin
            r_s8_off  <= r_s7_off;
            r_s8_limb <= r_s7_limb;
            r_s8_land <= r_s7_land;
            if (r_s7_day) begin
                r_s8_d <= 17'(FULL_Q16);
            end else if (r_s7_night) begin
                r_s8_d <= 17'(NIGHT_Q16);
            end else begin
                r_s8_d <= 17'(NIGHT_Q16) + 17'(w_ramp);
            end
        end
    end

    // stage 9: shade from limb and light, land or ocean color
    assign w_lit = 25'(r_s8_limb) * 25'(r_s8_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_valid <= 1'b0;
        end else if (w_en9) begin
            r_s9_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en9) begin
            r_s9_off   <= r_s8_off;
            r_s9_shade <= w_lit[24] ? 8'hFF : w_lit[23:16];
            r_s9_color <= r_s8_land ? r_land_color : r_ocean_color;
        end
    end

    // color scaling and packing
    gdn_scale565 u_scale (
        .i_color  (r_s9_color),
        .i_shade  (r_s9_shade),
        .o_rgb565 (w_scaled)
    );

    assign w_space565 = {r_space_color[23:19], r_space_color[15:10], r_space_color[7:3]};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_s9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_data <= r_s9_off ? w_space565 : w_scaled;
        end
    end

    // an empty result register must leave the whole pipe free to take a transfer
    `ASSERT_IMPLY(a_ready_when_drained, i_clk, i_rst_n, !r_out_valid, o_s_tready, "input stalled with empty output")
    // wrapped column always addresses the cosine table
    `ASSERT_IMPLY(a_col_in_range, i_clk, i_rst_n, r_s3_valid, 32'(r_s3_col) < MASK_W, "column out of range")
    // light factor stays between night level and full light
    `ASSERT_IMPLY(a_light_range, i_clk, i_rst_n, r_s8_valid, (r_s8_d >= 17'(NIGHT_Q16)) && (r_s8_d <= 17'(FULL_Q16)), "light factor out of range")
    // a new result only comes from a filled last stage
    `ASSERT_IMPLY(a_result_has_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_s9_valid), "result without source")

endmodule

// ===== dv/globe_day_night_pixel_shader_core_tb.sv =====
// self-checking testbench for globe_day_night_pixel_shader_core: loads both tables, walks a
// stimulus table, then random traffic under several register settings with random idling
// depends on gdn_pkg and the rtl of globe_day_night_pixel_shader_core
module globe_day_night_pixel_shader_core_tb import gdn_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MASK_W     = 360;
    localparam int     MASK_H     = 180;
    localparam int     MAP_BYTES  = (MASK_W * MASK_H + 7) / 8;
    localparam logic [1:0] OP_NONE = 2'd3;
    // lighting in q2.30 / q1.16
    localparam longint DAY_Q30    = 64'sd107374182;
    localparam longint NIGHT_Q16  = 64'sd18350;
    localparam longint FULL_Q16   = 64'sd65536;
    localparam longint RAMP_MUL   = 64'sd36;
    localparam longint RAMP_DIV   = 64'sd163840;
    localparam int     IDLE_PCT   = 27;
    localparam int     LAT_WAIT   = 20;
    localparam int     STALL_MAX  = 2000;
    localparam int     N_DIRECTED = 23;
    localparam int     N_PHASES   = 8;
    localparam int     PHASE_ITEMS = 50;
    localparam int     N_ROWS     = 7;

    // one input item; bits 93:0 follow the tdata layout
    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] cos_value;
        logic [7:0]         mask_byte;
        logic [12:0]        table_index;
        logic [14:0]        cos_lat;
        logic signed [15:0] sin_lat;
        logic [7:0]         limb_shade;
        logic signed [8:0]  col_offset;
        logic [7:0]         mask_row;
        logic               off_disc;
    } shader_item_t;

    typedef struct packed {
        shader_item_t item;
        logic         typed;
        logic [15:0]  want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [1:0]  s_tuser = '0;
    logic [95:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_cfg_ready;

    // shadow of the register file and both tables
    logic [8:0]         cfg_base    = 9'd296;
    logic signed [15:0] cfg_sin_dec = 16'sd0;
    logic signed [15:0] cfg_cos_dec = 16'sd32767;
    logic [23:0]        cfg_land    = 24'h3E6B34;
    logic [23:0]        cfg_ocean   = 24'h103248;
    logic [23:0]        cfg_space   = 24'h100A05;
    logic [7:0]         land_mem   [MAP_BYTES];
    logic signed [15:0] suncos_mem [MASK_W];

    logic [15:0] pixel_q [$];
    logic [15:0] want_px;
    int          err_count = 0;
    int          stall_cycles = 0;
    logic        calm = 1'b0;

    globe_day_night_pixel_shader_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mask rows that pixels may land on; the initial fill loads only these rows
    function automatic int used_row(int k);
        case (k)
            0: return 0;
            1: return 17;
            2: return 45;
            3: return 60;
            4: return 90;
            5: return 134;
            default: return MASK_H - 1;
        endcase
    endfunction

    // channel scale and 5/6/5 truncation
    function automatic logic [15:0] to_rgb565(logic [23:0] c, int s);
        int r;
        int g;
        int b;
        r = (int'(c[23:16]) * s) >> 8;
        g = (int'(c[15:8]) * s) >> 8;
        b = (int'(c[7:0]) * s) >> 8;
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // expected color of one shade item
    function automatic logic [15:0] shade_pixel(shader_item_t it);
        int     row;
        int     col;
        int     sh;
        int     bit_idx;
        longint p1;
        longint q;
        longint cz;
        longint light;
        logic   is_land;
        if (it.off_disc)
            return to_rgb565(cfg_space, 256);
        row = int'(it.mask_row);
        if (row >= MASK_H)
            row = MASK_H - 1;
        col = (int'(cfg_base) + int'(it.col_offset)) % MASK_W;
        if (col < 0)
            col += MASK_W;
        // zenith cosine, the cos product floored to q1.15 first
        p1 = longint'(it.sin_lat) * longint'(cfg_sin_dec);
        q  = (longint'(it.cos_lat) * longint'(cfg_cos_dec)) >>> 15;
        cz = p1 + q * longint'(suncos_mem[col]);
        if (cz >= DAY_Q30)
            light = FULL_Q16;
        else if (cz <= -DAY_Q30)
            light = NIGHT_Q16;
        else
            light = NIGHT_Q16 + ((cz + DAY_Q30) * RAMP_MUL) / RAMP_DIV;
        sh = int'((longint'(it.limb_shade) * light) >>> 16);
        if (sh > 255)
            sh = 255;
        bit_idx = row * MASK_W + col;
        is_land = land_mem[bit_idx >> 3][7 - (bit_idx & 7)];
        return to_rgb565(is_land ? cfg_land : cfg_ocean, sh);
    endfunction

    function automatic shader_item_t mk_load(logic [1:0] op, int idx, int mbyte, int cosv);
        shader_item_t it;
        it = {$urandom(), $urandom(), $urandom()};
        it.op = op;
        it.table_index = idx[12:0];
        it.mask_byte = mbyte[7:0];
        it.cos_value = cosv[15:0];
        return it;
    endfunction

    function automatic shader_item_t mk_pixel(int row, int offs, int limb, int sl, int cl);
        shader_item_t it;
        it = {$urandom(), $urandom(), $urandom()};
        it.op = OP_SHADE;
        it.off_disc = 1'b0;
        it.mask_row = row[7:0];
        it.col_offset = offs[8:0];
        it.limb_shade = limb[7:0];
        it.sin_lat = sl[15:0];
        it.cos_lat = cl[14:0];
        return it;
    endfunction

    // stimulus table of the directed part
    function automatic dir_row_t directed_row(int k);
        dir_row_t d;
        d.typed = 1'b0;
        d.want = '0;
        case (k)
            // off the disc with every other field low, then high
            0: begin
                d.item = '0;
                d.item.off_disc = 1'b1;
                d.typed = 1'b1;
                d.want = 16'h1040;
            end
            1: begin
                d.item = '1;
                d.item.op = OP_SHADE;
                d.typed = 1'b1;
                d.want = 16'h1040;
            end
            // zero limb shade is black whatever the light
            2: begin
                d.item = mk_pixel(90, 0, 0, 32767, 32767);
                d.typed = 1'b1;
                d.want = '0;
            end
            // unknown op, no result
            3: d.item = mk_load(OP_NONE, 0, 0, 0);
            4: d.item = '1;
            // loads out of range are dropped
            5: d.item = mk_load(OP_MASK, MAP_BYTES, 8'hFF, 0);
            6: d.item = mk_load(OP_MASK, 8191, 8'hAA, 0);
            7: d.item = mk_load(OP_COS, MASK_W, 0, 32767);
            8: d.item = mk_load(OP_COS, 8191, 0, -32768);
            // loads at both ends of each table
            9: d.item = mk_load(OP_MASK, 0, 8'hFF, 0);
            10: d.item = mk_load(OP_MASK, MAP_BYTES - 1, 8'h00, 0);
            11: d.item = mk_load(OP_COS, 0, 0, 32767);
            12: d.item = mk_load(OP_COS, MASK_W - 1, 0, -32768);
            // first and last mask cell, rows past the end, offset extremes
            13: d.item = mk_pixel(0, 64, 255, 0, 32767);
            14: d.item = mk_pixel(179, 63, 255, 0, 32767);
            15: d.item = mk_pixel(180, 63, 200, -32768, 32767);
            16: d.item = mk_pixel(255, -256, 255, 32767, 0);
            17: d.item = mk_pixel(17, 255, 255, -32768, 0);
            18: d.item = mk_pixel(45, -180, 255, 12000, 20000);
            19: d.item = mk_pixel(134, 180, 1, -12000, 20000);
            20: d.item = mk_pixel(90, 0, 128, 32767, 32767);
            // inside the twilight band
            21: d.item = mk_pixel(60, 10, 255, 5000, 100);
            default: d.item = mk_pixel(60, -10, 255, -5000, 3000);
        endcase
        return d;
    endfunction

    function automatic shader_item_t rand_item();
        shader_item_t it;
        int           sel;
        it = {$urandom(), $urandom(), $urandom()};
        sel = $urandom_range(0, 99);
        if (sel < 68) begin
            it.op = OP_SHADE;
            it.off_disc = ($urandom_range(0, 9) == 0);
            // a loaded row, or a row past the end that clamps to the last one
            if ($urandom_range(0, 6) != 0)
                it.mask_row = 8'(used_row($urandom_range(0, N_ROWS - 1)));
            else
                it.mask_row = 8'($urandom_range(MASK_H, 255));
            if ($urandom_range(0, 4) != 0)
                it.col_offset = 9'($urandom_range(0, 360) - 180);
            // small latitude terms land more pixels near the terminator
            if ($urandom_range(0, 3) == 0) begin
                it.sin_lat = 16'($urandom_range(0, 8191) - 4096);
                it.cos_lat = 15'($urandom_range(0, 4095));
            end
        end else if (sel < 82) begin
            it.op = OP_MASK;
            it.table_index = ($urandom_range(0, 9) != 0) ? 13'($urandom_range(0, MAP_BYTES - 1))
                                                         : 13'($urandom_range(MAP_BYTES, 8191));
        end else if (sel < 95) begin
            it.op = OP_COS;
            it.table_index = ($urandom_range(0, 9) != 0) ? 13'($urandom_range(0, MASK_W - 1))
                                                         : 13'($urandom_range(MASK_W, 8191));
        end else begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // one input transfer, then update the shadow state
    task automatic push_item(shader_item_t it, logic typed, logic [15:0] want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {2'b00, it[93:0]};
        do @(posedge clk); while (o_s_tready !== 1'b1);
        case (it.op)
            OP_SHADE: pixel_q.push_back(typed ? want : shade_pixel(it));
            OP_MASK: begin
                if (int'(it.table_index) < MAP_BYTES)
                    land_mem[it.table_index] = it.mask_byte;
            end
            OP_COS: begin
                if (int'(it.table_index) < MASK_W)
                    suncos_mem[it.table_index] = it.cos_value;
            end
            default: ;
        endcase
    endtask

    // stop sending, let every pixel and any trailing load clear the pipeline
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic write_settings(logic [8:0] base, logic [15:0] sdec, logic [15:0] cdec,
                                  logic [23:0] land, logic [23:0] ocean, logic [23:0] space);
        logic [2:0]  idx;
        logic [23:0] val;
        for (int r = 0; r < 6; r++) begin
            idx = 3'(r);
            case (idx)
                CFG_BASE_COLUMN: val = {15'd0, base};
                CFG_SIN_DECL:    val = {8'd0, sdec};
                CFG_COS_DECL:    val = {8'd0, cdec};
                CFG_LAND_COLOR:  val = land;
                CFG_OCEAN_COLOR: val = ocean;
                default:         val = space;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (o_cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
        cfg_base    = base;
        cfg_sin_dec = sdec;
        cfg_cos_dec = cdec;
        cfg_land    = land;
        cfg_ocean   = ocean;
        cfg_space   = space;
    endtask

    // result side: check each transfer, then pick the next ready
    always @(posedge clk) begin
        if (rst_n && o_m_tvalid === 1'b1 && m_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("pixel 0x%04h with none pending", o_m_tdata));
            end else begin
                want_px = pixel_q.pop_front();
                if (o_m_tdata !== want_px)
                    report_mismatch($sformatf("pixel_rgb565 got 0x%04h want 0x%04h",
                                              o_m_tdata, want_px));
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && m_tready) ||
            (cfg_valid && o_cfg_ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("watchdog: no transfer for %0d cycles", STALL_MAX);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        dir_row_t     d;
        shader_item_t it;
        int           counted;
        logic [8:0]   base;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every mask row a pixel can reach and the whole cosine table
        for (int k = 0; k < N_ROWS; k++) begin
            for (int b = (used_row(k) * MASK_W) >> 3;
                 b <= (used_row(k) * MASK_W + MASK_W - 1) >> 3; b++)
                push_item(mk_load(OP_MASK, b, $urandom_range(0, 255), 0), 1'b0, '0);
        end
        for (int i = 0; i < MASK_W; i++) begin
            if ($urandom_range(0, 7) == 0)
                push_item(mk_load(OP_COS, i, 0, $urandom_range(0, 1) ? 32767 : -32768),
                          1'b0, '0);
            else
                push_item(mk_load(OP_COS, i, 0, $urandom), 1'b0, '0);
        end

        // directed rows under the reset settings
        for (int k = 0; k < N_DIRECTED; k++) begin
            d = directed_row(k);
            push_item(d.item, d.typed, d.want);
        end

        // random traffic under extreme, wrapped and random settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: write_settings(9'd0, 16'h8000, 16'h8000, 24'h000000, 24'h000000, 24'h000000);
                1: write_settings(9'd511, 16'h7FFF, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                2: write_settings(9'd360, 16'h0000, 16'h7FFF, 24'h3E6B34, 24'h103248, 24'h100A05);
                default: begin
                    base = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(MASK_W, 511))
                                                       : 9'($urandom_range(0, MASK_W - 1));
                    write_settings(base, 16'($urandom), 16'($urandom), 24'($urandom),
                                   24'($urandom), 24'($urandom));
                end
            endcase
            calm = (ph == 4);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it = rand_item();
                push_item(it, 1'b0, '0);
                if (it.op != OP_NONE)
                    counted++;
            end
        end
        calm = 1'b0;

        wait_drained();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
